// ===== sv/hpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// hpdd_pkg: shared types, constants and helpers
// Register codes, angle constants and arithmetic helpers for the heading PID
// controller of a differential-drive vehicle.
// ----------------------------------------------------------------------------
package hpdd_pkg;

  // configuration register codes
  typedef enum logic [2:0] {
    REG_TARGET_HEADING = 3'd0,
    REG_GAIN_P         = 3'd1,
    REG_GAIN_I         = 3'd2,
    REG_GAIN_D         = 3'd3,
    REG_BASE_DUTY      = 3'd4,
    REG_DUTY_UPPER     = 3'd5,
    REG_DUTY_LOWER     = 3'd6,
    REG_REVERSE_MODE   = 3'd7
  } cfg_reg_t;

  // angle units are 1/16 degree
  localparam int FRAC_PER_DEG = 16;
  localparam int DEADBAND_DEG = 3;
  localparam int BAND         = DEADBAND_DEG * FRAC_PER_DEG;
  localparam int HALF_TURN    = 180 * FRAC_PER_DEG;
  localparam int FULL_TURN    = 360 * FRAC_PER_DEG;

  // integral saturation limits
  localparam logic signed [23:0] INT24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] INT24_MIN = -24'sh800000;

  // correction = sum / 1000, magnitude limited to CORR_SAT, which already
  // lies past every clamp bound on both sides
  localparam int CORR_SAT = 2048;
  localparam longint DIV_SAT = 64'(CORR_SAT) * 64'd1000;
  // ceil(2^31 / 1000): exact floor division for magnitudes below 2^21
  localparam int RECIP_SHIFT = 31;
  localparam logic [21:0] RECIP = 22'd2147484;

  // reset values of the registers
  localparam logic signed [15:0] GAIN_P_RESET   = 16'sd1000;
  localparam logic [9:0]         BASE_DUTY_RESET  = 10'd50;
  localparam logic [9:0]         DUTY_UPPER_RESET = 10'd100;

  // divide by 16 truncating toward zero
  function automatic logic signed [10:0] trunc16(input logic signed [14:0] x);
    logic signed [14:0] adj;
    adj = x + (x[14] ? 15'sd15 : 15'sd0);
    return 11'(adj >>> 4);
  endfunction

  // upper clamp first, then lower clamp
  function automatic logic [9:0] clamp_duty(input logic signed [13:0] d,
                                            input logic [9:0] upper,
                                            input logic [9:0] lower);
    logic signed [13:0] t;
    t = d;
    if (t > $signed({4'b0000, upper})) t = $signed({4'b0000, upper});
    if (t < $signed({4'b0000, lower})) t = $signed({4'b0000, lower});
    return t[9:0];
  endfunction

endpackage

// ===== sv/heading_pid_differential_drive_top.sv =====
// ----------------------------------------------------------------------------
// heading_pid_differential_drive_top: heading PID with wheel duty output
// Heading to m_tdata: input, pid, product, sum, magnitude, divide and duty registers.
// Throughput: one heading per cycle; the seven-stage valid/ready pipeline
// only holds when the output side stalls with every stage full.
// Headings whose error falls inside the deadband give no item.
// Reset (rst, synchronous) empties the pipeline, clears the integral and the
// previous error, and loads the register defaults.
// ----------------------------------------------------------------------------
module heading_pid_differential_drive_top (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // heading input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [12:0] heading
  // duty output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [9:0] left_duty, [19:10] right_duty, [20] drive_backward
);

  // configuration registers
  logic signed [12:0] target_heading;
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic [9:0]         base_duty;
  logic [9:0]         duty_upper;
  logic [9:0]         duty_lower;
  logic               reverse_mode;

  // controller state
  logic signed [23:0] integral_sum;
  logic signed [13:0] last_error;

  // pipeline control
  logic [7:1] vld;
  logic [7:1] rdy;
  logic       load_state;

  // stage registers
  logic signed [12:0] heading_q;
  logic signed [8:0]  p_q;
  logic signed [23:0] i_q;
  logic signed [9:0]  d_q;
  logic signed [24:0] prod_p;
  logic signed [39:0] prod_i;
  logic signed [25:0] prod_d;
  logic signed [41:0] sum_q;
  logic [20:0]        mag_q;
  logic               neg5;
  logic               sat5;
  logic [11:0]        cmag_q;
  logic               neg6;
  logic [9:0]         left_q;
  logic [9:0]         right_q;
  logic               bwd_q;

  // stage 2 logic
  logic signed [14:0] diff;
  logic signed [14:0] err_wide;
  logic signed [13:0] err;
  logic               in_band;
  logic signed [10:0] p_full;
  logic signed [10:0] last_trunc;
  logic signed [24:0] i_wide;
  logic signed [23:0] i_sat;
  logic signed [14:0] err_delta;
  logic signed [10:0] d_full;

  // stage 5 / 6 / 7 logic
  logic [41:0]        abs_val;
  logic [42:0]        recip_prod;
  logic [11:0]        cmag_next;
  logic signed [13:0] corr;
  logic signed [13:0] base_s;
  logic signed [13:0] duty_plus;
  logic signed [13:0] duty_minus;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      gain_p         <= hpdd_pkg::GAIN_P_RESET;
      gain_i         <= '0;
      gain_d         <= '0;
      base_duty      <= hpdd_pkg::BASE_DUTY_RESET;
      duty_upper     <= hpdd_pkg::DUTY_UPPER_RESET;
      duty_lower     <= '0;
      reverse_mode   <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (hpdd_pkg::cfg_reg_t'(cfg_index))
        hpdd_pkg::REG_TARGET_HEADING: target_heading <= cfg_data[12:0];
        hpdd_pkg::REG_GAIN_P:         gain_p         <= cfg_data;
        hpdd_pkg::REG_GAIN_I:         gain_i         <= cfg_data;
        hpdd_pkg::REG_GAIN_D:         gain_d         <= cfg_data;
        hpdd_pkg::REG_BASE_DUTY:      base_duty      <= cfg_data[9:0];
        hpdd_pkg::REG_DUTY_UPPER:     duty_upper     <= cfg_data[9:0];
        hpdd_pkg::REG_DUTY_LOWER:     duty_lower     <= cfg_data[9:0];
        hpdd_pkg::REG_REVERSE_MODE:   reverse_mode   <= cfg_data[0];
      endcase
    end
  end

  // ready chain: a stage loads when empty or when its item moves on
  always_comb begin
    rdy[7] = !vld[7] || m_tready;
    rdy[6] = !vld[6] || rdy[7];
    rdy[5] = !vld[5] || rdy[6];
    rdy[4] = !vld[4] || rdy[5];
    rdy[3] = !vld[3] || rdy[4];
    rdy[2] = !vld[2] || rdy[3];
    rdy[1] = !vld[1] || rdy[2];
  end

  assign s_tready = rdy[1];
  assign m_tvalid = vld[7];
  assign m_tdata  = {3'b000, bwd_q, right_q, left_q};

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= s_tvalid;
      if (rdy[2]) vld[2] <= vld[1] && !in_band;
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
      if (rdy[5]) vld[5] <= vld[4];
      if (rdy[6]) vld[6] <= vld[5];
      if (rdy[7]) vld[7] <= vld[6];
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rdy[1]) heading_q <= s_tdata[12:0];
  end

  // stage 2: wrapped error, deadband and pid terms
  always_comb begin
    diff = 15'(target_heading) - 15'(heading_q);
    if (diff <= -15'(hpdd_pkg::HALF_TURN)) begin
      err_wide = diff + 15'(hpdd_pkg::FULL_TURN);
    end else if (diff >= 15'(hpdd_pkg::HALF_TURN)) begin
      err_wide = diff - 15'(hpdd_pkg::FULL_TURN);
    end else begin
      err_wide = diff;
    end
    err     = err_wide[13:0];
    in_band = (err <= 14'(hpdd_pkg::BAND)) && (err >= -14'(hpdd_pkg::BAND));

    p_full     = hpdd_pkg::trunc16(15'(err));
    last_trunc = hpdd_pkg::trunc16(15'(last_error));
    i_wide     = 25'(integral_sum) + 25'(last_trunc);
    if (i_wide > 25'(hpdd_pkg::INT24_MAX)) begin
      i_sat = hpdd_pkg::INT24_MAX;
    end else if (i_wide < 25'(hpdd_pkg::INT24_MIN)) begin
      i_sat = hpdd_pkg::INT24_MIN;
    end else begin
      i_sat = i_wide[23:0];
    end
    err_delta = 15'(err) - 15'(last_error);
    d_full    = hpdd_pkg::trunc16(err_delta);
  end

  assign load_state = rdy[2] && vld[1] && !in_band;

  // integral and previous error advance only for items outside the deadband
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
    end else if (load_state) begin
      integral_sum <= i_sat;
      last_error   <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      p_q <= p_full[8:0];
      i_q <= i_sat;
      d_q <= d_full[9:0];
    end
  end

  // stage 3: gain products
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      prod_p <= 25'(gain_p) * 25'(p_q);
      prod_i <= 40'(gain_i) * 40'(i_q);
      prod_d <= 26'(gain_d) * 26'(d_q);
    end
  end

  // stage 4: sum of terms
  always_ff @(posedge clk) begin
    if (rdy[4]) sum_q <= 42'(prod_p) + 42'(prod_i) + 42'(prod_d);
  end

  // stage 5: magnitude and saturation flag
  assign abs_val = sum_q[41] ? 42'(-sum_q) : 42'(sum_q);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      mag_q <= abs_val[20:0];
      neg5  <= sum_q[41];
      sat5  <= (abs_val >= 42'(hpdd_pkg::DIV_SAT));
    end
  end

  // stage 6: divide magnitude by 1000 through the reciprocal
  assign recip_prod = 43'(mag_q) * 43'(hpdd_pkg::RECIP);
  assign cmag_next  = sat5 ? 12'(hpdd_pkg::CORR_SAT)
                           : {1'b0, recip_prod[hpdd_pkg::RECIP_SHIFT+10:hpdd_pkg::RECIP_SHIFT]};

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      cmag_q <= cmag_next;
      neg6   <= neg5;
    end
  end

  // stage 7: wheel duties and clamp
  always_comb begin
    corr       = neg6 ? -$signed({2'b00, cmag_q}) : $signed({2'b00, cmag_q});
    base_s     = $signed({4'b0000, base_duty});
    duty_plus  = base_s + corr;
    duty_minus = base_s - corr;
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      if (reverse_mode) begin
        right_q <= hpdd_pkg::clamp_duty(duty_plus, duty_upper, duty_lower);
        left_q  <= hpdd_pkg::clamp_duty(duty_minus, duty_upper, duty_lower);
      end else begin
        right_q <= hpdd_pkg::clamp_duty(duty_minus, duty_upper, duty_lower);
        left_q  <= hpdd_pkg::clamp_duty(duty_plus, duty_upper, duty_lower);
      end
      bwd_q <= reverse_mode;
    end
  end

`ifndef NO_ASSERTIONS
  // state moves only when an item outside the deadband leaves stage 1
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !load_state |=> $stable(integral_sum) && $stable(last_error))
    else $error("pid state changed without an item outside the deadband");

  // the stored error is either the reset value or outside the deadband
  a_last_error_band: assert property (@(posedge clk) disable iff (rst)
    (last_error == 14'sd0) || (last_error > 14'(hpdd_pkg::BAND))
      || (last_error < -14'(hpdd_pkg::BAND)))
    else $error("stored error lies inside the deadband");

  // correction magnitude never exceeds the saturation value
  a_corr_limit: assert property (@(posedge clk) disable iff (rst)
    vld[7:6] != 2'b00 |-> cmag_q <= 12'(hpdd_pkg::CORR_SAT))
    else $error("correction magnitude out of range");

  // the input side only stalls behind a stalled output item
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");
`endif

endmodule

// ===== tb/sv/hpdd_duty_checker.sv =====
// ----------------------------------------------------------------------------
// hpdd_duty_checker: duty prediction and comparison for the heading PID
// Follows the register writes, keeps its own integral and previous error,
// predicts the wheel duties of every accepted heading and compares each
// accepted duty item with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hpdd_duty_checker
  import hpdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [12:0] heading
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // [9:0] left_duty, [19:10] right_duty, [20] drive_backward
  output int          fail_count,
  output int          pending
);

  localparam longint ISUM_MAX = 64'sd8388607;
  localparam longint ISUM_MIN = -64'sd8388608;

  typedef struct packed {
    logic       drive_backward;
    logic [9:0] right_duty;
    logic [9:0] left_duty;
  } duty_item_t;

  // register copies
  logic signed [12:0] target_hdg;
  logic signed [15:0] kp, ki, kd;
  logic [9:0]         base_duty, duty_hi, duty_lo;
  logic               reverse;

  // controller state
  logic signed [23:0] integ_sum;
  logic signed [13:0] prev_err;

  duty_item_t expected_duties[$];
  int         errors = 0;

  // upper bound first, then lower bound
  function automatic longint clamp_to_limits(input longint d);
    if (d > longint'(duty_hi)) d = longint'(duty_hi);
    if (d < longint'(duty_lo)) d = longint'(duty_lo);
    return d;
  endfunction

  // one heading step: returns 1 and the duties when outside the deadband
  function automatic bit predict_duties(input logic [12:0] heading, output duty_item_t item);
    longint err, p_term, i_term, d_term, corr, right, left;
    item = '0;
    err = longint'(target_hdg) - longint'($signed(heading));
    // single wrap into the half-turn range
    if (err <= -HALF_TURN) err += FULL_TURN;
    else if (err >= HALF_TURN) err -= FULL_TURN;
    // deadband edge counts as inside
    if (err <= BAND && err >= -BAND) return 1'b0;
    p_term = err / FRAC_PER_DEG;
    i_term = longint'(integ_sum) + longint'(prev_err) / FRAC_PER_DEG;
    if (i_term > ISUM_MAX) i_term = ISUM_MAX;
    if (i_term < ISUM_MIN) i_term = ISUM_MIN;
    d_term = (err - longint'(prev_err)) / FRAC_PER_DEG;
    integ_sum = 24'(i_term);
    prev_err  = 14'(err);
    corr = (longint'(kp) * p_term + longint'(ki) * i_term + longint'(kd) * d_term) / 1000;
    if (reverse) begin
      right = longint'(base_duty) + corr;
      left  = longint'(base_duty) - corr;
    end else begin
      right = longint'(base_duty) - corr;
      left  = longint'(base_duty) + corr;
    end
    item.left_duty      = 10'(clamp_to_limits(left));
    item.right_duty     = 10'(clamp_to_limits(right));
    item.drive_backward = reverse;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // watch config, input and output channels
  always @(posedge clk) begin : watch
    duty_item_t want, got;
    if (rst) begin
      target_hdg = '0;
      kp         = GAIN_P_RESET;
      ki         = '0;
      kd         = '0;
      base_duty  = BASE_DUTY_RESET;
      duty_hi    = DUTY_UPPER_RESET;
      duty_lo    = '0;
      reverse    = 1'b0;
      integ_sum  = '0;
      prev_err   = '0;
      expected_duties.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_TARGET_HEADING: target_hdg = cfg_data[12:0];
          REG_GAIN_P:         kp         = cfg_data;
          REG_GAIN_I:         ki         = cfg_data;
          REG_GAIN_D:         kd         = cfg_data;
          REG_BASE_DUTY:      base_duty  = cfg_data[9:0];
          REG_DUTY_UPPER:     duty_hi    = cfg_data[9:0];
          REG_DUTY_LOWER:     duty_lo    = cfg_data[9:0];
          REG_REVERSE_MODE:   reverse    = cfg_data[0];
          default: ;
        endcase
      end
      // accepted heading
      if (s_tvalid && s_tready) begin
        if (predict_duties(s_tdata[12:0], want)) expected_duties.push_back(want);
      end
      // accepted duty item
      if (m_tvalid && m_tready) begin
        got = m_tdata[20:0];
        if (expected_duties.size() == 0) begin
          $display("%0t: duty item with none expected, got left %0d right %0d back %0d",
                   $time, got.left_duty, got.right_duty, got.drive_backward);
          errors++;
        end else begin
          want = expected_duties.pop_front();
          check_field("left_duty", want.left_duty, got.left_duty);
          check_field("right_duty", want.right_duty, got.right_duty);
          check_field("drive_backward", want.drive_backward, got.drive_backward);
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_duties.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for heading_pid_differential_drive_top
// Directed headings around the deadband, wrap and clamp corners, random
// phases with random register settings and idling on both sides, then two
// short runs that push the integral up and then down.
// ----------------------------------------------------------------------------
module tb_top;
  import hpdd_pkg::*;

  localparam int DRAIN_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int CLIMB_ITEMS     = 50;
  localparam int FALL_ITEMS      = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [12:0] heading
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [9:0] left_duty, [19:10] right_duty, [20] drive_backward

  int fail_count, pending;
  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int cycles = 0;
  logic signed [12:0] cur_target = '0;

  heading_pid_differential_drive_top DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  hpdd_duty_checker duty_chk (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic signed [12:0] tgt, input logic signed [15:0] gp,
                               input logic signed [15:0] gi, input logic signed [15:0] gd,
                               input logic [9:0] base, input logic [9:0] hi,
                               input logic [9:0] lo, input logic rev);
    write_reg(REG_TARGET_HEADING, 16'(tgt));
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_BASE_DUTY, {6'b0, base});
    write_reg(REG_DUTY_UPPER, {6'b0, hi});
    write_reg(REG_DUTY_LOWER, {6'b0, lo});
    write_reg(REG_REVERSE_MODE, {15'b0, rev});
    cfg_wr_en <= 1'b0;
    cur_target = tgt;
  endtask

  // wait for all duty items, then let deadband headings leave the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_heading(input logic [12:0] h);
    bit taken;
    // sender idle cycles
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, h};
    // ready is stable from the falling edge to the next rising edge
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic signed [15:0] pick_gain();
    int sel;
    sel = $urandom_range(99);
    if (sel < 7) return 16'sh8000;
    if (sel < 14) return 16'sh7FFF;
    if (sel < 20) return '0;
    return 16'(int'($urandom_range(6000)) - 3000);
  endfunction

  task automatic random_settings();
    logic [9:0] a, b, t;
    logic signed [12:0] tgt;
    a = 10'($urandom_range(1023));
    b = 10'($urandom_range(1023));
    // mostly an ordered clamp window, sometimes an inverted one
    if ($urandom_range(99) < 75 && a < b) begin
      t = a;
      a = b;
      b = t;
    end
    if ($urandom_range(99) < 85) tgt = 13'(int'($urandom_range(5760)) - 2880);
    else tgt = 13'($urandom());
    load_settings(tgt, pick_gain(), pick_gain(), pick_gain(),
                  10'($urandom_range(1023)), a, b, 1'($urandom()));
  endtask

  function automatic logic [12:0] pick_heading();
    int sel, off;
    sel = $urandom_range(99);
    off = int'($urandom_range(120)) - 60;
    if (sel < 70) return 13'(int'($urandom_range(5760)) - 2880);
    if (sel < 88) return 13'(int'(cur_target) + off);
    return 13'($urandom());
  endfunction

  // stimulus and verdict
  initial begin
    int dir_a[14];
    int dir_b[5];
    int dir_c[5];
    dir_a = '{0, 48, -48, 49, -49, 2879, -2879, 2880, -2880, 4095, -4096, 16, -17, 300};
    dir_b = '{-2880, 0, -1, 1000, 2880};
    dir_c = '{2880, -2000, 100, -2832, -2833};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    src_gap_pct    = 12;
    sink_stall_pct = 75;

    // deadband edges, wrap edges, field extremes
    load_settings(0, 1000, 250, -500, 512, 1023, 0, 1'b0);
    foreach (dir_a[k]) send_heading(13'(dir_a[k]));
    settle();
    // inverted clamp window, reverse mode, extreme gains
    load_settings(2880, -32768, 32767, -32768, 1023, 0, 1023, 1'b1);
    foreach (dir_b[k]) send_heading(13'(dir_b[k]));
    settle();
    load_settings(-2880, 32767, -32768, 32767, 0, 1023, 0, 1'b0);
    foreach (dir_c[k]) send_heading(13'(dir_c[k]));
    settle();

    // random phases
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 3) begin
        src_gap_pct    = 12;
        sink_stall_pct = 75;
      end else if (ph < 6) begin
        src_gap_pct    = 75;
        sink_stall_pct = 12;
      end else begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      random_settings();
      repeat (ITEMS_PER_PHASE) send_heading(pick_heading());
      settle();
    end

    // integral ramp up, then down
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    load_settings(0, 0, 32767, 0, 512, 1023, 0, 1'b0);
    repeat (CLIMB_ITEMS) send_heading(-13'sd2879);
    settle();
    load_settings(0, 0, -32768, 0, 512, 1023, 0, 1'b0);
    repeat (FALL_ITEMS) send_heading(13'sd2879);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
